@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decimal multiplier RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a clocked implication, held off while reset is high
`define ASSERT_IMPLY(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds at a clock edge
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/ddm_pkg.sv @@
// Package for the decimal digit multiplier: operation codes, digit
// constants and the digit step result type. No dependencies.
package ddm_pkg;

  localparam int DIGIT_W = 4;
  localparam int OP_W    = 2;

  // Operation codes carried in the input word
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0]         RADIX     = 4'd10;

  // Reciprocal of ten, exact for step sums up to 99
  localparam logic [7:0] RECIP10       = 8'd205;
  localparam int         RECIP10_SHIFT = 11;

  // Result of one multiply-accumulate digit step
  typedef struct packed {
    logic [DIGIT_W-1:0] carry;
    logic [DIGIT_W-1:0] digit;
  } step_t;

endpackage

@@ rtl/ddm_step.sv @@
// One decimal digit step: a * b + sum + carry, split into digit and carry.
// Depends on ddm_pkg.
module ddm_step (
  input  logic [ddm_pkg::DIGIT_W-1:0] a,
  input  logic [ddm_pkg::DIGIT_W-1:0] b,
  input  logic [ddm_pkg::DIGIT_W-1:0] sum_in,
  input  logic [ddm_pkg::DIGIT_W-1:0] carry_in,
  output ddm_pkg::step_t              result
);

  logic [6:0]  prod;
  logic [14:0] scaled;
  logic [3:0]  quot;
  logic [6:0]  rem;

  // Form the digit product plus the incoming sum and carry (at most 99)
  assign prod = 7'(a) * 7'(b) + 7'(sum_in) + 7'(carry_in);

  // Divide by ten through the reciprocal, then take the remainder
  assign scaled = 15'(prod) * 15'(ddm_pkg::RECIP10);
  assign quot   = scaled[ddm_pkg::RECIP10_SHIFT +: 4];
  assign rem    = prod - 7'(quot) * 7'(ddm_pkg::RADIX);

  assign result.carry = quot;
  assign result.digit = rem[3:0];

endmodule

@@ rtl/decimal_digit_multiplier_core.sv @@
// Decimal digit multiplier: schoolbook long multiplication over digit memories.
// Depends on ddm_pkg, ddm_step and assert_macros.svh.
//
// A load word is taken while idle. A compute word multiplies each digit pair
// with a read state and a write state on the partial-sum memory, writes each
// row carry in a carry state, then reads and checks each scanned product
// position before emitting it; a stalled output holds the scan.
// One word at a time is in work; loads are taken while a product digit waits.
// Reset clears counts, the overflow flag and control; memories are not cleared.
`include "assert_macros.svh"

module decimal_digit_multiplier_core #(
  parameter int MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  // Input word: [1:0] operation, [5:2] digit, [7:6] zero
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  // Output word: [3:0] product_digit, [4] overflow, [7:5] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  localparam int DW = ddm_pkg::DIGIT_W;
  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int PW = $clog2(2 * MAX_DIGITS);
  localparam int PD = 2 * MAX_DIGITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ROW_RD  = 3'd1;
  localparam logic [2:0] ST_ROW_WR  = 3'd2;
  localparam logic [2:0] ST_CARRY   = 3'd3;
  localparam logic [2:0] ST_OUT_RD  = 3'd4;
  localparam logic [2:0] ST_OUT_CHK = 3'd5;
  localparam logic [2:0] ST_EMPTY   = 3'd6;

  logic [2:0] state;

  // Operand and partial-sum memories
  logic [DW-1:0] mem_a  [MAX_DIGITS];
  logic [DW-1:0] mem_b  [MAX_DIGITS];
  logic [DW-1:0] mem_ps [PD];
  logic [DW-1:0] rd_a;
  logic [DW-1:0] rd_b;
  logic [DW-1:0] rd_ps;

  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic          ovf;

  logic [AW-1:0] ia;
  logic [AW-1:0] jb;
  logic [AW-1:0] jb_top;
  logic [DW-1:0] carry;
  logic          first_row;
  logic [PW-1:0] k;
  logic [PW-1:0] last_pos;
  logic          seen_nz;

  logic          out_valid;
  logic [DW-1:0] out_digit;
  logic          out_last;
  logic          out_ovf;

  logic                    in_acc;
  logic [ddm_pkg::OP_W-1:0] in_op;
  logic [DW-1:0]           in_digit;
  logic [DW-1:0]           load_digit;
  logic                    a_we;
  logic                    b_we;
  logic                    a_full;
  logic                    b_full;
  logic [PW-1:0]           pos;
  logic                    ps_we;
  logic [PW-1:0]           ps_waddr;
  logic [DW-1:0]           ps_wdata;
  logic                    rd_en;
  logic [PW-1:0]           ps_raddr;
  logic [DW-1:0]           step_sum;
  logic                    out_free;
  logic                    out_load;
  logic                    at_last;
  logic                    skip;
  ddm_pkg::step_t          step;

  // Decode the input word
  assign s_tready   = (state == ST_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign in_op      = s_tdata[1:0];
  assign in_digit   = s_tdata[5:2];
  assign load_digit = (in_digit > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : in_digit;
  assign a_full     = (cnt_a >= CW'(MAX_DIGITS));
  assign b_full     = (cnt_b >= CW'(MAX_DIGITS));
  assign a_we       = in_acc && (in_op == ddm_pkg::OP_LOAD_A) && !a_full;
  assign b_we       = in_acc && (in_op == ddm_pkg::OP_LOAD_B) && !b_full;

  // Product position of the current digit pair
  assign pos = PW'(ia) + PW'(jb) + PW'(1);

  // The first row finds every position still clear
  assign step_sum = first_row ? '0 : rd_ps;

  ddm_step u_step (
    .a        (rd_a),
    .b        (rd_b),
    .sum_in   (step_sum),
    .carry_in (carry),
    .result   (step)
  );

  // Route partial-sum memory accesses
  always_comb begin
    ps_we    = 1'b0;
    ps_waddr = pos;
    ps_wdata = step.digit;
    rd_en    = 1'b0;
    ps_raddr = pos;
    case (state)
      ST_ROW_RD: begin
        rd_en = 1'b1;
      end
      ST_ROW_WR: begin
        ps_we = 1'b1;
      end
      ST_CARRY: begin
        ps_we    = 1'b1;
        ps_waddr = PW'(ia);
        ps_wdata = carry;
      end
      ST_OUT_RD: begin
        rd_en    = 1'b1;
        ps_raddr = k;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Operand memories: write on load, read for each digit pair
  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[cnt_a[AW-1:0]] <= load_digit;
    end
    if (b_we) begin
      mem_b[cnt_b[AW-1:0]] <= load_digit;
    end
    if (rd_en) begin
      rd_a <= mem_a[ia];
      rd_b <= mem_b[jb];
    end
  end

  // Partial-sum memory
  always_ff @(posedge clk) begin
    if (ps_we) begin
      mem_ps[ps_waddr] <= ps_wdata;
    end
    if (rd_en) begin
      rd_ps <= mem_ps[ps_raddr];
    end
  end

  // Output scan decisions
  assign out_free = !out_valid || m_tready;
  assign at_last  = (k == last_pos);
  assign skip     = !seen_nz && (rd_ps == '0) && !at_last;
  assign out_load = ((state == ST_OUT_CHK) && !skip && out_free) ||
                    ((state == ST_EMPTY) && out_free);

  // Sequencer, counts and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Load a new word or drop the accepted one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_op)
              ddm_pkg::OP_LOAD_A: begin
                if (a_full) ovf <= 1'b1;
                else cnt_a <= cnt_a + CW'(1);
              end
              ddm_pkg::OP_LOAD_B: begin
                if (b_full) ovf <= 1'b1;
                else cnt_b <= cnt_b + CW'(1);
              end
              ddm_pkg::OP_COMPUTE: begin
                cnt_a     <= '0;
                cnt_b     <= '0;
                ia        <= AW'(cnt_a - CW'(1));
                jb        <= AW'(cnt_b - CW'(1));
                jb_top    <= AW'(cnt_b - CW'(1));
                last_pos  <= PW'(cnt_a) + PW'(cnt_b) - PW'(1);
                carry     <= '0;
                first_row <= 1'b1;
                if (cnt_a == '0 || cnt_b == '0) state <= ST_EMPTY;
                else state <= ST_ROW_RD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ROW_RD: begin
          state <= ST_ROW_WR;
        end
        ST_ROW_WR: begin
          carry <= step.carry;
          if (jb == '0) begin
            state <= ST_CARRY;
          end else begin
            jb    <= jb - AW'(1);
            state <= ST_ROW_RD;
          end
        end
        ST_CARRY: begin
          carry     <= '0;
          first_row <= 1'b0;
          if (ia == '0) begin
            k       <= '0;
            seen_nz <= 1'b0;
            state   <= ST_OUT_RD;
          end else begin
            ia    <= ia - AW'(1);
            jb    <= jb_top;
            state <= ST_ROW_RD;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_CHK;
        end
        ST_OUT_CHK: begin
          if (skip) begin
            k     <= k + PW'(1);
            state <= ST_OUT_RD;
          end else if (out_free) begin
            out_digit <= rd_ps;
            out_last  <= at_last;
            out_ovf   <= ovf;
            seen_nz   <= 1'b1;
            if (at_last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + PW'(1);
              state <= ST_OUT_RD;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_digit <= '0;
            out_last  <= 1'b1;
            out_ovf   <= ovf;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the output word
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_ovf, out_digit};
  assign m_tlast  = out_last;

  // Checks on the sequencer and datapath
  `ASSERT_IMPLY(a_step_digit, clk, rst, (state == ST_ROW_WR) |-> (step.digit <= ddm_pkg::DIGIT_MAX), "digit step left a value above nine")
  `ASSERT_NEVER(a_count_range, clk, rst, (cnt_a > CW'(MAX_DIGITS)) || (cnt_b > CW'(MAX_DIGITS)), "operand count beyond capacity")
  `ASSERT_IMPLY(a_ovf_sticky, clk, rst, ovf |=> ovf, "overflow flag dropped without reset")
  `ASSERT_IMPLY(a_more_digits, clk, rst, (m_tvalid && m_tready && !m_tlast) |-> (state != ST_IDLE), "product ended without a last word")

endmodule

@@ tb/decimal_digit_multiplier_core_test.sv @@
// Self-checking testbench for decimal_digit_multiplier_core: a directed table, then
// random operand loads, noise words and computes, checked against a digit-level predictor.
// Depends on ddm_pkg and the core RTL.
module decimal_digit_multiplier_core_test;

  localparam int DIGIT_W = ddm_pkg::DIGIT_W;
  localparam int OP_W = ddm_pkg::OP_W;
  localparam int MAX_DIGITS = 32;
  localparam int RANDOM_ITEMS = 55;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One expected product digit
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic is_last;
    logic ovf;
  } digit_word_t;

  // One directed row: a word repeated reps times, with an optional typed result
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [DIGIT_W-1:0] digit;
    logic [5:0] reps;
    logic drain;
    logic fixed;
    logic [DIGIT_W-1:0] fix_digit;
    logic fix_ovf;
  } dir_row_t;

  localparam int NUM_ROWS = 21;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;

  // Predictor state
  logic [DIGIT_W-1:0] first_op[MAX_DIGITS];
  logic [DIGIT_W-1:0] second_op[MAX_DIGITS];
  int first_len = 0;
  int second_len = 0;
  logic ovf_sticky = 1'b0;
  digit_word_t product_q[$];

  int mismatches = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  dir_row_t dir_rows[NUM_ROWS];

  decimal_digit_multiplier_core #(.MAX_DIGITS(MAX_DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Multiply the held operands column-wise and queue the stripped product digits
  function automatic void queue_product();
    int sums[2*MAX_DIGITS];
    int total;
    int lead;
    digit_word_t w;
    total = first_len + second_len;
    for (int k = 0; k < 2*MAX_DIGITS; k++) sums[k] = 0;
    for (int i = 0; i < first_len; i++)
      for (int j = 0; j < second_len; j++)
        sums[i+j+1] += int'(first_op[i]) * int'(second_op[j]);
    // Ripple decimal carries towards the most significant position
    for (int k = total - 1; k > 0; k--) begin
      sums[k-1] += sums[k] / 10;
      sums[k] = sums[k] % 10;
    end
    lead = 0;
    while (lead + 1 < total && sums[lead] == 0) lead++;
    for (int k = lead; k < total; k++) begin
      w.digit = sums[k][DIGIT_W-1:0];
      w.is_last = (k + 1 == total);
      w.ovf = ovf_sticky;
      product_q.push_back(w);
    end
  endfunction

  // Update the predictor for one accepted word
  function automatic void take_word(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] dig,
                                    input logic fixed, input digit_word_t fixed_word);
    logic [DIGIT_W-1:0] d;
    d = (dig > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : dig;
    case (op)
      ddm_pkg::OP_LOAD_A: begin
        if (first_len < MAX_DIGITS) begin
          first_op[first_len] = d;
          first_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      ddm_pkg::OP_LOAD_B: begin
        if (second_len < MAX_DIGITS) begin
          second_op[second_len] = d;
          second_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      ddm_pkg::OP_COMPUTE: begin
        if (fixed) begin
          product_q.push_back(fixed_word);
        end else if (first_len == 0 || second_len == 0) begin
          product_q.push_back('{digit: 4'd0, is_last: 1'b1, ovf: ovf_sticky});
        end else begin
          queue_product();
        end
        first_len = 0;
        second_len = 0;
      end
      default: ;
    endcase
  endfunction

  // Drive one word at the falling edge and hold it until accepted
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] dig,
                           input logic fixed, input digit_word_t fixed_word);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, dig, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    take_word(op, dig, fixed, fixed_word);
  endtask

  // Drop valid and wait for every queued product digit to leave
  task automatic drain_products();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (product_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DIGIT_W-1:0] pick_digit();
    if ($urandom_range(99) < 85) return DIGIT_W'($urandom_range(9));
    return DIGIT_W'($urandom_range(15, 10));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 88) return $urandom_range(6, 1);
    return $urandom_range(MAX_DIGITS, 7);
  endfunction

  // Random output stall
  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= 23);
  end

  // Compare each accepted product digit with the oldest expectation
  always @(posedge clk) begin
    digit_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (product_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected product digit: digit=%0d last=%0b ovf=%0b",
                   m_tdata[3:0], m_tlast, m_tdata[4]);
      end else begin
        want = product_q.pop_front();
        if (m_tdata[3:0] !== want.digit || m_tlast !== want.is_last ||
            m_tdata[4] !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"product digit mismatch: expected digit=%0d last=%0b ovf=%0b,",
                      " got digit=%0d last=%0b ovf=%0b"},
                     want.digit, want.is_last, want.ovf, m_tdata[3:0], m_tlast, m_tdata[4]);
        end
      end
    end
  end

  initial begin
    int items;
    int len_a;
    int len_b;
    digit_word_t no_word;
    no_word = '0;

    // Directed words; typed results only for the empty-operand cases
    dir_rows = '{
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b1, 4'd0, 1'b0},  // both operands empty
      '{ddm_pkg::OP_LOAD_A, 4'd9, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd15, 6'd1, 1'b0, 1'b1, 4'd0, 1'b0}, // second operand empty
      '{ddm_pkg::OP_LOAD_B, 4'd4, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b1, 4'd0, 1'b0},  // first operand empty
      '{ddm_pkg::OP_LOAD_A, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_LOAD_B, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},  // zero keeps one digit
      '{ddm_pkg::OP_LOAD_A, 4'd15, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},  // clamped to nine
      '{OP_UNUSED, 4'd15, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},           // unused code, ignored
      '{ddm_pkg::OP_LOAD_B, 4'd10, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd5, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_LOAD_A, 4'd9, 6'd32, 1'b0, 1'b0, 4'd0, 1'b0},  // full operands
      '{ddm_pkg::OP_LOAD_B, 4'd9, 6'd32, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_LOAD_A, 4'd1, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_LOAD_B, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},   // leading zero
      '{ddm_pkg::OP_LOAD_B, 4'd7, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0},
      '{ddm_pkg::OP_LOAD_B, 4'd5, 6'd33, 1'b1, 1'b0, 4'd0, 1'b0},  // one past capacity
      '{ddm_pkg::OP_COMPUTE, 4'd0, 6'd1, 1'b0, 1'b0, 4'd0, 1'b0}
    };

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].drain) drain_products();
      for (int n = 0; n < dir_rows[r].reps; n++)
        send_word(dir_rows[r].op, dir_rows[r].digit, dir_rows[r].fixed,
                  '{digit: dir_rows[r].fix_digit, is_last: 1'b1, ovf: dir_rows[r].fix_ovf});
    end
    send_word(ddm_pkg::OP_LOAD_A, 4'd3, 1'b0, no_word);
    send_word(ddm_pkg::OP_COMPUTE, 4'd0, 1'b1, '{digit: 4'd0, is_last: 1'b1, ovf: 1'b1});

    // Random operand pairs with noise words between the loads
    items = 0;
    while (items < RANDOM_ITEMS) begin
      no_gaps = (items >= 15 && items < 40);
      len_a = pick_len();
      len_b = pick_len();
      while (len_a + len_b > 0) begin
        if ($urandom_range(99) < 5)
          send_word(OP_UNUSED, DIGIT_W'($urandom_range(15)), 1'b0, no_word);
        if (len_b == 0 || (len_a > 0 && $urandom_range(1) == 0)) begin
          send_word(ddm_pkg::OP_LOAD_A, pick_digit(), 1'b0, no_word);
          len_a--;
        end else begin
          send_word(ddm_pkg::OP_LOAD_B, pick_digit(), 1'b0, no_word);
          len_b--;
        end
        items++;
      end
      send_word(ddm_pkg::OP_COMPUTE, DIGIT_W'($urandom_range(15)), 1'b0, no_word);
      items++;
    end
    no_gaps = 1'b0;

    // Let the last product drain, then allow for trailing output
    drain_products();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ddm_pkg.sv
rtl/ddm_step.sv
rtl/decimal_digit_multiplier_core.sv
tb/decimal_digit_multiplier_core_test.sv
